>>> sv/sfr_pkg.sv
// Shared constants, types and helper functions for the string find-and-replace block.
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int LENGTH_BITS = 16;
    localparam int BYTE_W      = 8;
    localparam int WIN_W       = MAX_PATTERN * BYTE_W;
    localparam int TEXT_W      = 64;
    localparam int BUF_W       = 64;
    localparam int MAX_REPL    = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int PROJ_W      = 22;
    localparam int PROJ_FLOOR_I = -1048576;

    localparam logic signed [PROJ_W-1:0] PROJ_FLOOR = PROJ_W'(PROJ_FLOOR_I);
    localparam logic [LENGTH_BITS-1:0]   COUNT_MAX  = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_TEXT       = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_TEXT   = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_INPUT_LENGTH       = 3'd4,
        REG_OUTPUT_CAPACITY    = 3'd5
    } cfg_reg_t;

    // Pattern lengths of zero act as one, lengths beyond the window act as the window size.
    function automatic logic [3:0] clamp_pattern_length(input logic [3:0] len);
        logic [3:0] res;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (len > 4'(MAX_PATTERN)) begin
            res = 4'(MAX_PATTERN);
        end else begin
            res = len;
        end
        return res;
    endfunction

    function automatic logic [WIN_W-1:0] byte_mask(input logic [3:0] len);
        logic [WIN_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (4'(i) < len) begin
                mask[BYTE_W*i +: BYTE_W] = '1;
            end
        end
        return mask;
    endfunction

endpackage

>>> sv/string_find_replace.sv
// Top level of the streaming string find-and-replace block.
//
// Usage: configuration registers are written through cfg_we/cfg_addr/cfg_wdata while the
// block is idle. Input bytes arrive on the s_ channel (valid/ready), one byte per transfer,
// with s_is_final marking the last byte of a string. Output bytes leave on the m_ channel
// (valid/ready), one byte per transfer; the last transfer of a string has m_end_of_string
// high and carries the replacement count. A string whose output would be empty ends with a
// bare marker that has m_byte_valid low.
// Latency: the results of an accepted byte appear on the m_ channel in the next cycle.
// Throughput: one input byte per cycle while each byte yields at most one output byte and
// m_ready is high. A byte that yields k output bytes (a replacement, a window flush or a
// capacity fallback, k up to 8) holds the next input back until its last output byte goes
// out: the single output lane drains the buffer one byte per cycle while m_ready is high.
// Reset (aresetn low, synchronous) returns the registers to their defaults, clears the
// stream state and empties the result buffer.
// When the receiver stalls, the buffered results hold. s_ready is low while more than one
// byte is buffered, and with one byte left it follows m_ready.
module string_find_replace (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sfr_pkg::TEXT_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_in_byte,
    input  logic                            s_is_final,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_byte_valid,
    output logic                            m_end_of_string,
    output logic [sfr_pkg::LENGTH_BITS-1:0] m_replace_count
);

    logic [sfr_pkg::TEXT_W-1:0] pattern_text_reg;
    logic [3:0]                 pattern_length_reg;
    logic [sfr_pkg::TEXT_W-1:0] replacement_text_reg;
    logic [3:0]                 replacement_length_reg;
    logic [15:0]                input_length_reg;
    logic [16:0]                output_capacity_reg;

    logic [sfr_pkg::WIN_W-1:0]        win_reg, win_next;
    logic [2:0]                       fill_reg, fill_next;
    logic [sfr_pkg::LENGTH_BITS-1:0]  count_reg, count_next;
    logic signed [sfr_pkg::PROJ_W-1:0] proj_reg, proj_next;
    logic                             copy_reg, copy_next;
    logic                             open_reg, open_next;
    logic [3:0]                       act_reg, act_next;

    logic [sfr_pkg::BUF_W-1:0]        buf_reg;
    logic [3:0]                       cnt_reg;
    logic                             bvalid_reg;
    logic                             eos_reg;
    logic [sfr_pkg::LENGTH_BITS-1:0]  rcount_reg;

    logic [3:0]                        cur_len;
    logic signed [sfr_pkg::PROJ_W-1:0] cur_proj;
    logic [3:0]                        r_eff;
    logic [sfr_pkg::WIN_W-1:0]         w;
    logic [3:0]                        nfill;
    logic                              full;
    logic                              hit;
    logic                              fit;
    logic signed [sfr_pkg::PROJ_W-1:0] cand;
    logic signed [sfr_pkg::PROJ_W-1:0] limit;
    logic [sfr_pkg::BUF_W-1:0]         res_data;
    logic [3:0]                        res_cnt;
    logic                              res_bvalid;
    logic [sfr_pkg::LENGTH_BITS-1:0]   rep_count;
    logic                              s_xfer;
    logic                              m_xfer;
    logic                              last_out;

    assign s_xfer   = s_valid && s_ready;
    assign m_xfer   = m_valid && m_ready;
    assign s_ready  = (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && m_ready);
    assign m_valid  = (cnt_reg != 4'd0);
    assign last_out = eos_reg && (cnt_reg == 4'd1);

    assign m_out_byte      = buf_reg[7:0];
    assign m_byte_valid    = bvalid_reg;
    assign m_end_of_string = last_out;
    assign m_replace_count = last_out ? rcount_reg : '0;

    always_comb begin
        cur_len  = open_reg ? act_reg : sfr_pkg::clamp_pattern_length(pattern_length_reg);
        cur_proj = open_reg ? proj_reg
                            : $signed({{(sfr_pkg::PROJ_W-16){1'b0}}, input_length_reg});
        r_eff    = (replacement_length_reg > 4'(sfr_pkg::MAX_REPL))
                   ? 4'(sfr_pkg::MAX_REPL) : replacement_length_reg;

        w = win_reg;
        w[sfr_pkg::BYTE_W*fill_reg +: sfr_pkg::BYTE_W] = s_in_byte;
        nfill = {1'b0, fill_reg} + 4'd1;
        full  = (nfill >= cur_len);
        hit   = (((w ^ pattern_text_reg[sfr_pkg::WIN_W-1:0]) & sfr_pkg::byte_mask(cur_len))
                 == '0);
        cand  = cur_proj + $signed({{(sfr_pkg::PROJ_W-4){1'b0}}, r_eff})
                         - $signed({{(sfr_pkg::PROJ_W-4){1'b0}}, cur_len});
        limit = $signed({{(sfr_pkg::PROJ_W-17){1'b0}}, output_capacity_reg})
                - $signed(sfr_pkg::PROJ_W'(1));
        fit   = (cand <= limit);

        win_next   = win_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        proj_next  = cur_proj;
        copy_next  = copy_reg;
        open_next  = 1'b1;
        act_next   = cur_len;
        res_data   = '0;
        res_cnt    = 4'd0;
        res_bvalid = 1'b1;

        if (copy_reg) begin
            res_data[7:0] = s_in_byte;
            res_cnt       = 4'd1;
        end else begin
            win_next = w;
            fill_next = nfill[2:0];
            res_data[sfr_pkg::WIN_W-1:0] = w;
            if (full) begin
                if (hit && fit) begin
                    res_data  = replacement_text_reg[sfr_pkg::BUF_W-1:0];
                    res_cnt   = r_eff;
                    fill_next = 3'd0;
                    if (count_reg != sfr_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    proj_next = (cand < sfr_pkg::PROJ_FLOOR) ? sfr_pkg::PROJ_FLOOR : cand;
                end else if (hit) begin
                    res_cnt   = cur_len;
                    fill_next = 3'd0;
                    copy_next = 1'b1;
                end else begin
                    res_cnt   = s_is_final ? cur_len : 4'd1;
                    win_next  = w >> sfr_pkg::BYTE_W;
                    fill_next = 3'(cur_len - 4'd1);
                end
            end else begin
                res_cnt = s_is_final ? nfill : 4'd0;
            end
        end

        rep_count = count_next;

        if (s_is_final) begin
            if (res_cnt == 4'd0) begin
                res_cnt    = 4'd1;
                res_bvalid = 1'b0;
                res_data   = '0;
            end
            fill_next  = 3'd0;
            count_next = '0;
            copy_next  = 1'b0;
            open_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_text_reg       <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_text_reg   <= '0;
            replacement_length_reg <= 4'd0;
            input_length_reg       <= '0;
            output_capacity_reg    <= 17'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sfr_pkg::REG_PATTERN_TEXT:       pattern_text_reg       <= cfg_wdata;
                sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_wdata[3:0];
                sfr_pkg::REG_REPLACEMENT_TEXT:   replacement_text_reg   <= cfg_wdata;
                sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_wdata[3:0];
                sfr_pkg::REG_INPUT_LENGTH:       input_length_reg       <= cfg_wdata[15:0];
                sfr_pkg::REG_OUTPUT_CAPACITY:    output_capacity_reg    <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= 3'd0;
            count_reg <= '0;
            proj_reg  <= '0;
            copy_reg  <= 1'b0;
            open_reg  <= 1'b0;
            act_reg   <= 4'd1;
            cnt_reg   <= 4'd0;
        end else begin
            if (s_xfer) begin
                fill_reg   <= fill_next;
                count_reg  <= count_next;
                proj_reg   <= proj_next;
                copy_reg   <= copy_next;
                open_reg   <= open_next;
                act_reg    <= act_next;
                cnt_reg    <= res_cnt;
            end else if (m_xfer) begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            win_reg    <= win_next;
            buf_reg    <= res_data;
            bvalid_reg <= res_bvalid;
            eos_reg    <= s_is_final;
            rcount_reg <= rep_count;
        end else if (m_xfer) begin
            buf_reg <= buf_reg >> sfr_pkg::BYTE_W;
        end
    end

`ifndef SYNTH
    a_ready_only_near_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 4'd1) |-> !s_ready)
        else $error("input accepted while result buffer still holds several bytes");

    a_final_clears_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_final) |=> (!open_reg && fill_reg == 3'd0 && !copy_reg))
        else $error("stream state not cleared after final byte");

    a_copy_empty_window: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_reg |-> (fill_reg == 3'd0))
        else $error("window not empty in copy mode");

    a_fill_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> ({1'b0, fill_reg} < act_reg))
        else $error("window fill reached pattern length between bytes");

    a_bare_marker_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_end_of_string && cnt_reg == 4'd1))
        else $error("bare marker is not the last transfer of a string");
`endif

endmodule
